>>> sv/awtd_pkg.sv
`default_nettype none

package awtd_pkg;

	localparam int MAX_WINDOW_DEF = 16;

	localparam int AREA_W  = 12;
	localparam int WIN_W   = 5;
	localparam int RATIO_W = 12;
	localparam int MIN_W   = 10;
	localparam int PROD_W  = MIN_W + RATIO_W;
	localparam int FRAC_W  = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [MIN_W-1:0]   MIN_START         = MIN_W'(999);
	localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = WIN_W'(16);
	localparam logic [RATIO_W-1:0] AREA_RATIO_RST    = RATIO_W'(128);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_RATIO    = 1'b1;

	localparam logic REQ_PUSH  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [1:0] STATUS_INVALID  = 2'd0;
	localparam logic [1:0] STATUS_OPENING  = 2'd1;
	localparam logic [1:0] STATUS_COVERING = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic push;
		logic clear;
	} log_ctrl_t;

endpackage

`default_nettype wire

>>> sv/awtd_log.sv
`default_nettype none

module awtd_log #(
	parameter int MAX_WINDOW = awtd_pkg::MAX_WINDOW_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  awtd_pkg::log_ctrl_t                  ctrl,
	input  wire  [awtd_pkg::AREA_W-1:0]          sample,
	input  wire  [$clog2(MAX_WINDOW)-1:0]        rd_idx,
	output logic [awtd_pkg::AREA_W-1:0]          rd_data
);
	import awtd_pkg::*;

	logic [AREA_W-1:0] log_q [MAX_WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				log_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				log_q[i] <= '0;
			end
		end else if (ctrl.push) begin
			for (int i = MAX_WINDOW - 1; i > 0; i--) begin
				log_q[i] <= log_q[i-1];
			end
			log_q[0] <= sample;
		end
	end

	assign rd_data = log_q[rd_idx];

endmodule

`default_nettype wire

>>> sv/area_window_trend_detector_unit.sv
// A push is scanned one log entry per cycle through a single min/max compare unit, over
// the effective window length W (1 to MAX_WINDOW), then evaluated and reported; a clear is
// reported without a scan. Input is not ready until the result has been loaded into the
// output register (held while the output stalls), so no new word is taken meanwhile.
// Reset: asynchronous, active low; clears the log, the sequencer, the result valid flag
// and restores window_length to 16 and area_ratio to 128.
`default_nettype none

module area_window_trend_detector_unit #(
	parameter int MAX_WINDOW = awtd_pkg::MAX_WINDOW_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               req_type,
	input  wire  [awtd_pkg::AREA_W-1:0]       area_sample,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [1:0]                        trend_status,
	output logic [awtd_pkg::AREA_W-1:0]       area_spread,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [awtd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [awtd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import awtd_pkg::*;

	localparam int IDXW = $clog2(MAX_WINDOW);

	state_t state_q, state_d;
	log_ctrl_t log_ctrl;

	logic [WIN_W-1:0]   window_length_q;
	logic [RATIO_W-1:0] area_ratio_q;

	logic [IDXW-1:0]    scan_idx_q;
	logic [IDXW-1:0]    last_q;
	logic [IDXW-1:0]    last_d;
	logic [MIN_W-1:0]   min_q;
	logic [AREA_W-1:0]  max_q;
	logic [IDXW-1:0]    min_idx_q;
	logic [IDXW-1:0]    max_idx_q;
	logic [AREA_W-1:0]  spread_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AREA_W-1:0]  rd_data;
	logic               out_valid_q;
	logic               in_accept;
	logic               res_load;
	logic               pass;
	logic [1:0]         status_d;

	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	awtd_log #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (log_ctrl),
		.sample (area_sample),
		.rd_idx (scan_idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			area_ratio_q    <= AREA_RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WIN_W-1:0];
				REG_AREA_RATIO:    area_ratio_q    <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (req_type == REQ_CLEAR) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == last_q) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		log_ctrl.push  = in_accept && (req_type == REQ_PUSH);
		log_ctrl.clear = in_accept && (req_type == REQ_CLEAR);
		res_load       = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (window_length_q == '0) begin
			last_d = '0;
		end else if (32'(window_length_q) > MAX_WINDOW) begin
			last_d = IDXW'(MAX_WINDOW - 1);
		end else begin
			last_d = IDXW'(32'(window_length_q) - 32'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			scan_idx_q <= '0;
			last_q     <= last_d;
			min_q      <= MIN_START;
			max_q      <= '0;
			min_idx_q  <= '0;
			max_idx_q  <= '0;
			spread_q   <= '0;
		end else if (state_q == ST_SCAN) begin
			if (rd_data < AREA_W'(min_q)) begin
				min_q     <= MIN_W'(rd_data);
				min_idx_q <= scan_idx_q;
			end
			if (rd_data > max_q) begin
				max_q     <= rd_data;
				max_idx_q <= scan_idx_q;
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end else if (state_q == ST_EVAL) begin
			spread_q <= (max_q > AREA_W'(min_q)) ? (max_q - AREA_W'(min_q)) : '0;
			prod_q   <= PROD_W'(min_q) * PROD_W'(area_ratio_q);
		end
	end

	always_comb begin
		pass = (min_idx_q != max_idx_q) && (spread_q != '0) &&
			(PROD_W'({spread_q, FRAC_W'(0)}) >= prod_q);
		priority if (!pass) begin
			status_d = STATUS_INVALID;
		end else if (min_idx_q > max_idx_q) begin
			status_d = STATUS_OPENING;
		end else begin
			status_d = STATUS_COVERING;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			trend_status <= status_d;
			area_spread  <= spread_q;
		end
	end

	assign out_valid = out_valid_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q <= last_q))
		else $error("scan index beyond window");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !in_ready)
		else $error("input ready right after accepting a word");

	a_trend_has_spread: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (trend_status != STATUS_INVALID)) |-> (area_spread != '0))
		else $error("trend reported with zero spread");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trend_status != 2'd3))
		else $error("undefined trend status");

endmodule

`default_nettype wire

>>> tb/sv/area_window_trend_detector_checker.sv
module area_window_trend_detector_checker #(
	parameter int MAX_WINDOW = awtd_pkg::MAX_WINDOW_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire                              in_ready,
	input  wire                              req_type,
	input  wire  [awtd_pkg::AREA_W-1:0]      area_sample,
	input  wire                              out_valid,
	input  wire                              out_ready,
	input  wire  [1:0]                       trend_status,
	input  wire  [awtd_pkg::AREA_W-1:0]      area_spread,
	input  wire                              cfg_valid,
	input  wire                              cfg_ready,
	input  wire  [awtd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [awtd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import awtd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0]        status;
		logic [AREA_W-1:0] spread;
	} trend_t;

	trend_t             trend_q[$];
	trend_t             want;
	logic [AREA_W-1:0]  area_hist [MAX_WINDOW];
	logic [WIN_W-1:0]   win_cfg;
	logic [RATIO_W-1:0] ratio_cfg;
	int                 errs;

	// shift the history, then scan the newest entries for the first strict min and max
	function automatic trend_t trend_after_push(input logic [AREA_W-1:0] smp);
		int unsigned w, lo, hi, lo_at, hi_at, spread;
		trend_t      t;
		for (int i = MAX_WINDOW - 1; i > 0; i--)
			area_hist[i] = area_hist[i - 1];
		area_hist[0] = smp;
		w = 32'(win_cfg);
		if (w == 0)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		lo    = 32'(MIN_START);
		hi    = 0;
		lo_at = 0;
		hi_at = 0;
		for (int i = 0; i < w; i++) begin
			if (32'(area_hist[i]) < lo) begin
				lo    = 32'(area_hist[i]);
				lo_at = i;
			end
			if (32'(area_hist[i]) > hi) begin
				hi    = 32'(area_hist[i]);
				hi_at = i;
			end
		end
		spread   = (hi > lo) ? hi - lo : 0;
		t.spread = AREA_W'(spread);
		if (lo_at == hi_at || spread == 0 || (spread << FRAC_W) < lo * 32'(ratio_cfg))
			t.status = STATUS_INVALID;
		else if (lo_at > hi_at)
			t.status = STATUS_OPENING;
		else
			t.status = STATUS_COVERING;
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trend_q.delete();
			foreach (area_hist[i])
				area_hist[i] = '0;
			win_cfg     = WINDOW_LENGTH_RST;
			ratio_cfg   = AREA_RATIO_RST;
			errs        = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (trend_q.size() == 0) begin
					errs++;
					if (errs <= REPORT_LIMIT)
						$display("[%0t] unexpected word: status %0d spread %0d",
							$time, trend_status, area_spread);
				end else begin
					want = trend_q.pop_front();
					if (trend_status !== want.status || area_spread !== want.spread) begin
						errs++;
						if (errs <= REPORT_LIMIT)
							$display({"[%0t] mismatch: expected status %0d spread %0d,",
								" got status %0d spread %0d"},
								$time, want.status, want.spread, trend_status,
								area_spread);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LENGTH: win_cfg   = cfg_data[WIN_W-1:0];
					REG_AREA_RATIO:    ratio_cfg = cfg_data[RATIO_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_CLEAR) begin
					foreach (area_hist[i])
						area_hist[i] = '0;
					want.status = STATUS_INVALID;
					want.spread = '0;
					trend_q.push_back(want);
				end else begin
					trend_q.push_back(trend_after_push(area_sample));
				end
			end
			mismatches  <= errs;
			outstanding <= trend_q.size();
		end
	end

endmodule

>>> tb/sv/area_window_trend_detector_unit_tb.sv
module area_window_trend_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import awtd_pkg::*;

	localparam int QUIET_LIMIT   = 3000;
	localparam int RANDOM_BLOCKS = 20;
	localparam int BLOCK_ITEMS   = 72;

	typedef enum int {
		RISE,
		FALL,
		HOLD,
		NOISE_LOW,
		NOISE_WIDE,
		JITTER
	} shape_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  req_type    = REQ_PUSH;
	logic [AREA_W-1:0]     area_sample = '0;
	logic                  out_ready   = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_WINDOW_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	wire                   in_ready;
	wire                   out_valid;
	wire  [1:0]            trend_status;
	wire  [AREA_W-1:0]     area_spread;
	wire                   cfg_ready;
	int                    mismatches;
	int                    outstanding;
	int                    idle_pct  = 0;
	int                    stall_pct = 0;
	int                    quiet     = 0;

	area_window_trend_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.area_sample  (area_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trend_status (trend_status),
		.area_spread  (area_spread),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	area_window_trend_detector_checker trend_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.area_sample  (area_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trend_status (trend_status),
		.area_spread  (area_spread),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_word(input logic rq, input logic [AREA_W-1:0] smp);
		if ($urandom_range(99) < idle_pct) begin
			in_valid    <= 1'b0;
			area_sample <= AREA_W'($urandom);
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rq;
		area_sample <= smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold off until every expected word has come back
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] win_word,
			input logic [CFG_DATA_W-1:0] ratio_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WINDOW_LENGTH;
		cfg_data  <= win_word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_AREA_RATIO;
		cfg_data  <= ratio_word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_phase(input int p);
		case (p % 4)
			0: begin
				idle_pct  = 0;
				stall_pct <= 0;
			end
			1: begin
				idle_pct  = 56;
				stall_pct <= 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct <= 56;
			end
			default: begin
				idle_pct  = 17;
				stall_pct <= 17;
			end
		endcase
	endtask

	task automatic run_random_block(input int n);
		int     lvl;
		int     step;
		int     run_left;
		shape_t shape;
		lvl      = $urandom_range(0, 900);
		run_left = 0;
		step     = 1;
		shape    = HOLD;
		for (int k = 0; k < n; k++) begin
			if (run_left == 0) begin
				shape    = shape_t'($urandom_range(0, 5));
				run_left = $urandom_range(3, 20);
				step     = $urandom_range(1, 120);
			end
			run_left--;
			case (shape)
				RISE:       lvl = lvl + step;
				FALL:       lvl = lvl - step;
				HOLD:       ;
				NOISE_LOW:  lvl = $urandom_range(0, 998);
				NOISE_WIDE: lvl = $urandom_range(0, 4095);
				default:    lvl = lvl + int'($urandom_range(0, 40)) - 20;
			endcase
			if (lvl < 0)
				lvl = 0;
			if (lvl > 4095)
				lvl = 4095;
			if ($urandom_range(99) < 3)
				send_word(REQ_CLEAR, AREA_W'($urandom));
			else
				send_word(REQ_PUSH, AREA_W'(lvl));
		end
	endtask

	initial begin
		logic [WIN_W-1:0]      win;
		logic [CFG_DATA_W-1:0] ratio;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(REQ_CLEAR, 12'hFFF);
		send_word(REQ_PUSH, 12'd0);
		send_word(REQ_PUSH, 12'd4095);
		send_word(REQ_PUSH, 12'd1);
		send_word(REQ_PUSH, 12'd300);
		send_word(REQ_PUSH, 12'd150);
		send_word(REQ_PUSH, 12'd998);

		drain;
		set_config(12'hFE1, 12'h000);
		send_word(REQ_PUSH, 12'd999);
		send_word(REQ_PUSH, 12'd1000);
		send_word(REQ_PUSH, 12'd4095);
		send_word(REQ_PUSH, 12'd998);

		drain;
		set_config(12'h01F, 12'hFFF);
		send_word(REQ_PUSH, 12'd5);
		send_word(REQ_PUSH, 12'd3);
		send_word(REQ_PUSH, 12'd7);
		send_word(REQ_PUSH, 12'd900);

		drain;
		set_config(12'h020, 12'd256);
		send_word(REQ_PUSH, 12'd200);
		send_word(REQ_CLEAR, 12'd0);

		drain;
		set_config(12'd3, 12'd64);
		send_word(REQ_PUSH, 12'd10);
		send_word(REQ_PUSH, 12'd40);
		send_word(REQ_PUSH, 12'd20);
		send_word(REQ_PUSH, 12'd5);
		send_word(REQ_PUSH, 12'd60);
		send_word(REQ_PUSH, 12'd60);

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			drain;
			case ($urandom_range(0, 5))
				0:       win = 5'd1;
				1:       win = WIN_W'(MAX_WINDOW_DEF);
				2:       win = 5'd0;
				3:       win = WIN_W'($urandom_range(17, 31));
				default: win = WIN_W'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 4))
				0:       ratio = 12'd0;
				1:       ratio = 12'hFFF;
				2:       ratio = CFG_DATA_W'($urandom_range(0, 4095));
				default: ratio = CFG_DATA_W'($urandom_range(1, 400));
			endcase
			set_config({7'($urandom), win}, ratio);
			set_phase(b);
			run_random_block(BLOCK_ITEMS);
		end

		drain;
		repeat (MAX_WINDOW_DEF + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
